@@ design/lfu_pkg.sv @@
// Package for the LFU cache table: shared command/status types.
// No dependencies.
`timescale 1ns / 1ps
package lfu_pkg;
  typedef struct packed {
    logic    start;   // load the item, begin scan
    logic    step;    // process one slot
    logic    commit;  // apply the update
  } dp_ctrl_t;

  typedef struct packed {
    logic last;  // the scan has reached the last slot
  } dp_stat_t;
endpackage

@@ design/lfu_datapath.sv @@
// Datapath of the LFU cache table: slot registers, scan unit, update logic.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_datapath #(
  parameter int Entries = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfu_pkg::dp_ctrl_t ctrl_i,
  output lfu_pkg::dp_stat_t stat_o,
  input  logic [4:0]       capacity_i,
  input  logic             opcode_i,
  input  logic [31:0]      key_i,
  input  logic [31:0]      value_i,
  output logic             hit_o,
  output logic [31:0]      read_value_o,
  output logic             evicted_o,
  output logic [31:0]      evicted_key_o
);
  import lfu_pkg::*;
  localparam int Iw = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int Cw = $clog2(Entries + 1);

  logic [Entries-1:0] valid_q;
  logic [31:0]        key_q   [Entries];
  logic [31:0]        val_q   [Entries];
  logic [31:0]        cnt_q   [Entries];
  logic [Iw-1:0]      rank_q  [Entries];

  logic          op_q;
  logic [31:0]   ikey_q, ival_q;
  logic [Iw-1:0] idx_q;
  logic          hit_q, have_q, free_q;
  logic [Iw-1:0] found_q, vic_q, free_idx_q;
  logic [Cw-1:0] occ_q;

  assign stat_o.last = (idx_q == Iw'(Entries - 1));

  // scan: one slot per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; hit_q <= 1'b0; have_q <= 1'b0; free_q <= 1'b0;
      occ_q <= '0; op_q <= 1'b0;
      found_q <= '0; vic_q <= '0; free_idx_q <= '0;
    end else if (ctrl_i.start) begin
      idx_q <= '0; hit_q <= 1'b0; have_q <= 1'b0; free_q <= 1'b0;
      occ_q <= '0; op_q <= opcode_i;
    end else if (ctrl_i.step) begin
      if (!stat_o.last) idx_q <= idx_q + 1'b1;
      if (valid_q[idx_q]) begin
        occ_q <= occ_q + 1'b1;
        if (!hit_q && key_q[idx_q] == ikey_q) begin
          hit_q <= 1'b1; found_q <= idx_q;
        end
        if (!have_q || cnt_q[idx_q] < cnt_q[vic_q] ||
            (cnt_q[idx_q] == cnt_q[vic_q] && rank_q[idx_q] > rank_q[vic_q])) begin
          have_q <= 1'b1; vic_q <= idx_q;
        end
      end else if (!free_q) begin
        free_q <= 1'b1; free_idx_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      ikey_q <= key_i; ival_q <= value_i;
    end
  end

  // commit decision
  logic [4:0]    cap;
  logic          do_put, do_touch, do_evict, do_ins;
  logic [Iw-1:0] ins_idx;
  always_comb begin
    cap      = (capacity_i > 5'(Entries > 31 ? 31 : Entries)) && (Entries < 32)
               ? 5'(Entries) : capacity_i;
    do_put   = op_q && (cap != '0);
    do_touch = hit_q && (!op_q || do_put);
    do_ins   = do_put && !hit_q;
    do_evict = do_ins && have_q && ({{(32-Cw){1'b0}}, occ_q} >= {27'd0, cap});
    ins_idx  = do_evict ? vic_q : free_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.commit && do_ins && (do_evict || free_q)) begin
      valid_q[ins_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      hit_o         <= hit_q;
      read_value_o  <= op_q ? 32'd0 : (hit_q ? val_q[found_q] : 32'hFFFF_FFFF);
      evicted_o     <= do_evict;
      evicted_key_o <= do_evict ? key_q[vic_q] : 32'd0;
      for (int i = 0; i < Entries; i++) begin
        if (do_touch && valid_q[i]) begin
          if (Iw'(i) == found_q) rank_q[i] <= '0;
          else if (rank_q[i] < rank_q[found_q]) rank_q[i] <= rank_q[i] + 1'b1;
        end else if (do_ins && valid_q[i]) begin
          if (do_evict && Iw'(i) == vic_q) rank_q[i] <= '0;
          else if (!do_evict || rank_q[i] < rank_q[vic_q])
            rank_q[i] <= rank_q[i] + 1'b1;
        end else if (do_ins && free_q && !do_evict && Iw'(i) == free_idx_q) begin
          rank_q[i] <= '0;
        end
      end
      if (do_touch) begin
        if (cnt_q[found_q] != 32'hFFFF_FFFF) cnt_q[found_q] <= cnt_q[found_q] + 1'b1;
        if (op_q) val_q[found_q] <= ival_q;
      end
      if (do_ins && (do_evict || free_q)) begin
        key_q[ins_idx] <= ikey_q;
        val_q[ins_idx] <= ival_q;
        cnt_q[ins_idx] <= 32'd1;
      end
    end
  end
endmodule

@@ design/lfu_ctrl.sv @@
// Controller of the LFU cache table: scan sequencing and output handshake.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lfu_pkg::dp_ctrl_t ctrl_o,
  input  lfu_pkg::dp_stat_t stat_i
);
  import lfu_pkg::*;
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_SCAN = 3'b010, ST_DONE = 3'b100
  } state_e;
  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ctrl_o   = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin ctrl_o.start = 1'b1; state_d = ST_SCAN; end
      end
      ST_SCAN: begin
        ctrl_o.step = 1'b1;
        if (stat_i.last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1; ovalid_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d;
    end
  end
  assign out_valid_o = ovalid_q;
endmodule

@@ design/lfu_cache_table.sv @@
// Top level of the LFU cache table: controller plus datapath.
// Depends on lfu_pkg, lfu_ctrl, lfu_datapath.
`timescale 1ns / 1ps
// LFU key-value cache with LRU tie break. Each get or put scans every slot,
// one slot per cycle, for the key match, the occupancy, the first free slot
// and the eviction victim; a commit step then applies the update and loads
// the result register. The result register lets the next item be taken while
// a result waits; a commit stalls only if the prior result has not been
// transferred. Capacity writes must come while idle.
module lfu_cache_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // hit[0], read_value[32:1], evicted[33],
                                     // evicted_key[65:34], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data       // capacity
);
  import lfu_pkg::*;
  dp_ctrl_t   ctrl;
  dp_stat_t   stat;
  logic [4:0] cap_q;
  logic       hit, ev;
  logic [31:0] rd, evk;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 5'd16;
    else if (cfg_valid) cap_q <= cfg_data;
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .ctrl_o(ctrl), .stat_i(stat)
  );

  lfu_datapath #(.Entries(MAX_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .capacity_i(cap_q),
    .opcode_i(s_axis_tuser), .key_i(s_axis_tdata[31:0]),
    .value_i(s_axis_tdata[63:32]),
    .hit_o(hit), .read_value_o(rd), .evicted_o(ev), .evicted_key_o(evk)
  );

  assign m_axis_tdata = {6'd0, evk, ev, rd, hit};
endmodule

@@ design/lfu_checker.sv @@
// Port-level checker for the LFU cache table, bound to the top level.
// Depends on lfu_cache_table.
`timescale 1ns / 1ps
module lfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // a get never evicts; eviction only with a miss
  a_evhit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[0])
    else $error("eviction reported on hit");
  // no eviction means no key
  a_evkey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[65:34] == 32'd0)
    else $error("evicted key without eviction");
  // an accepted item is not immediately followed by another accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted back to back");
endmodule

bind lfu_cache_table lfu_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ dv/tb_top.sv @@
// Testbench for lfu_cache_table: random and directed get/put traffic checked
// against a behavioral LFU/LRU cache model held in a scoreboard class.
// Depends on the RTL top lfu_cache_table only.
`timescale 1ns / 1ps
module tb_top;
  localparam int SLOTS = 16;
  localparam bit OP_GET = 1'b0;
  localparam bit OP_PUT = 1'b1;

  typedef struct packed {
    logic [31:0] evicted_key;
    logic        evicted;
    logic [31:0] read_value;
    logic        hit;
  } lookup_res_t;

  // Cache model plus queue of expected lookup results.
  class cache_scoreboard;
    bit          valid_q[SLOTS];
    logic [31:0] key_q[SLOTS];
    logic [31:0] val_q[SLOTS];
    logic [31:0] cnt_q[SLOTS];
    int          rank_q[SLOTS];
    int          cap;
    lookup_res_t pending[$];
    int          mismatches;

    function void init();
      for (int i = 0; i < SLOTS; i++) valid_q[i] = 0;
      cap = 16;
      mismatches = 0;
    endfunction

    function void touch(int s);
      int r;
      r = rank_q[s];
      if (cnt_q[s] != 32'hFFFF_FFFF) cnt_q[s]++;
      for (int i = 0; i < SLOTS; i++)
        if (valid_q[i] && i != s && rank_q[i] < r) rank_q[i]++;
      rank_q[s] = 0;
    endfunction

    // Note an accepted request; apply it to the model and queue its result.
    function void note_request(bit op, logic [31:0] k, logic [31:0] v);
      lookup_res_t res;
      int found, occ, eff, vic;
      bit have;
      res = '0; found = 0; occ = 0; have = 0; vic = 0;
      eff = cap > SLOTS ? SLOTS : cap;
      for (int i = 0; i < SLOTS; i++) begin
        if (!valid_q[i]) continue;
        occ++;
        if (!res.hit && key_q[i] == k) begin
          res.hit = 1; found = i;
        end
      end
      if (op == OP_GET) begin
        if (res.hit) begin
          res.read_value = val_q[found]; touch(found);
        end else begin
          res.read_value = 32'hFFFF_FFFF;
        end
      end else if (eff != 0) begin
        if (res.hit) begin
          val_q[found] = v; touch(found);
        end else begin
          if (occ >= eff) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!valid_q[i]) continue;
              if (!have || cnt_q[i] < cnt_q[vic] ||
                  (cnt_q[i] == cnt_q[vic] && rank_q[i] > rank_q[vic])) begin
                have = 1; vic = i;
              end
            end
            if (have) begin
              res.evicted = 1; res.evicted_key = key_q[vic];
              valid_q[vic] = 0;
              for (int i = 0; i < SLOTS; i++)
                if (valid_q[i] && rank_q[i] > rank_q[vic]) rank_q[i]--;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (!valid_q[i]) begin
              for (int j = 0; j < SLOTS; j++) if (valid_q[j]) rank_q[j]++;
              valid_q[i] = 1; key_q[i] = k; val_q[i] = v;
              cnt_q[i] = 1; rank_q[i] = 0;
              break;
            end
          end
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(lookup_res_t got);
      lookup_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit || got.read_value !== exp_r.read_value ||
          got.evicted !== exp_r.evicted || got.evicted_key !== exp_r.evicted_key) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit=%b rd=%h ev=%b evk=%h, got hit=%b rd=%h ev=%b evk=%h",
                   exp_r.hit, exp_r.read_value, exp_r.evicted, exp_r.evicted_key,
                   got.hit, got.read_value, got.evicted, got.evicted_key);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  cache_scoreboard sb;
  bit stall_en = 1;
  logic [31:0] key_pool[8];

  lfu_cache_table u_top (.*);

  always #10 clk_i = ~clk_i;

  // Receiver stalls: random ready pattern, with an off switch for stretches.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[65:0]);
    m_axis_tready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task automatic send_req(bit op, logic [31:0] k, logic [31:0] v);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {v, k};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, k, v);
  endtask

  task automatic gap_idle(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_and_idle();
    gap_idle(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_capacity(int c);
    cfg_valid <= 1;
    cfg_data  <= c[4:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 0;
    sb.cap = c;
    @(posedge clk_i);
  endtask

  // Random phase: keys mostly from a small pool so hits and evictions occur.
  task automatic random_phase(int n);
    int burst;
    logic [31:0] k;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      stall_en = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        k = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, 7)] +
            $urandom_range(0, 12) : $urandom();
        send_req(1'($urandom_range(0, 1)), k, $urandom());
      end
      if ($urandom_range(0, 2) != 0) gap_idle($urandom_range(1, 30));
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFF0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: misses, inserts, hits, extremes, updates, eviction tie break.
    send_req(OP_GET, 32'h0000_0000, 32'h0);
    send_req(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_GET, 32'h8000_0000, 32'h0);
    send_req(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_PUT, 32'h8000_0000, 32'h0000_0000);
    send_req(OP_GET, 32'h8000_0000, 32'h0);
    drain_and_idle();
    write_capacity(2);
    send_req(OP_PUT, 32'h1, 32'h11);
    send_req(OP_PUT, 32'h2, 32'h22);
    send_req(OP_PUT, 32'h3, 32'h33);
    send_req(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_req(OP_PUT, 32'h4, 32'h44);
    drain_and_idle();
    write_capacity(0);
    send_req(OP_PUT, 32'h5, 32'h55);
    send_req(OP_PUT, 32'h4, 32'h99);
    send_req(OP_GET, 32'h4, 32'h0);
    drain_and_idle();
    write_capacity(1);
    send_req(OP_PUT, 32'h6, 32'h66);
    send_req(OP_PUT, 32'h7, 32'h77);
    drain_and_idle();
    write_capacity(31);
    random_phase(450);
    drain_and_idle();
    write_capacity(3);
    random_phase(350);
    drain_and_idle();
    write_capacity(0);
    random_phase(100);
    drain_and_idle();
    write_capacity(16);
    random_phase(450);
    drain_and_idle();
    write_capacity(9);
    random_phase(400);
    drain_and_idle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
